// File: rtl/thsh_pkg.sv
`timescale 1ns / 1ps

package thsh_pkg;

  localparam int RdW     = 22;
  localparam int OhmW    = 20;
  localparam int CoefW   = 48;
  localparam int ProdW   = OhmW + RdW;      // series*reading and v*nominal
  localparam int ExpW    = 6;               // leading-one index of a ProdW word
  localparam int FracW   = 30;              // log2 fraction bits
  localparam int LogW    = ExpW + FracW;
  localparam int Ln2W    = 26;
  localparam int LW      = 31;              // signed L, 24 fraction bits
  localparam int AccW    = 63;              // Horner accumulator, 48 fraction bits
  localparam int QW      = 20;              // quotient bits kept (millikelvin)
  localparam int TempW   = 20;
  localparam int FaultW  = 2;
  localparam int CfgIdxW = 3;

  localparam logic [Ln2W-1:0] Ln2Q26 = 26'd46516320;
  localparam logic [AccW-1:0] SatLim = 63'h3FFF_FFFF_FFFF_FFFF;

  localparam logic signed [TempW-1:0] TempMax = 20'sd400000;
  localparam logic signed [TempW-1:0] TempMin = -20'sd200000;
  localparam logic [QW+1:0]           ZeroCmK = 22'd273150;

  localparam logic [RdW-1:0]          RefReset   = 22'd1800000;
  localparam logic [OhmW-1:0]         SerReset   = 20'd10000;
  localparam logic [OhmW-1:0]         NomReset   = 20'd10000;
  localparam logic signed [CoefW-1:0] CoefAReset = 48'sd944071575487;
  localparam logic signed [CoefW-1:0] CoefBReset = 48'sd86526477447;
  localparam logic signed [CoefW-1:0] CoefCReset = 48'sd2868660668;
  localparam logic signed [CoefW-1:0] CoefDReset = 48'sd255965237;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REF    = 3'd0,
    REG_SERIES = 3'd1,
    REG_NOMINAL = 3'd2,
    REG_COEF_A = 3'd3,
    REG_COEF_B = 3'd4,
    REG_COEF_C = 3'd5,
    REG_COEF_D = 3'd6
  } cfg_reg_e;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE = 2'd0,
    FAULT_ZERO = 2'd1,
    FAULT_HIGH = 2'd2
  } fault_e;

  typedef struct packed {
    logic   vld;
    fault_e fault;
  } tag_t;

endpackage

// File: rtl/thsh_log_ratio.sv
`timescale 1ns / 1ps

module thsh_log_ratio (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  thsh_pkg::tag_t                     tag_i,
  input  logic [thsh_pkg::ProdW-1:0]         num_i,
  input  logic [thsh_pkg::ProdW-1:0]         den_i,
  output thsh_pkg::tag_t                     tag_o,
  output logic signed [thsh_pkg::LW-1:0]     l_o
);
  import thsh_pkg::*;

  localparam int MW = FracW + 1;    // mantissa Q1.30
  localparam int PW = LogW + Ln2W;

  logic [ProdW-1:0] x [2];
  logic [ExpW-1:0]  e_d [2];
  logic [MW-1:0]    m_d [2];

  logic [MW-1:0]    m_q [2][FracW+1];
  logic [ExpW-1:0]  e_q [2][FracW+1];
  logic [FracW-1:0] f_q [2][FracW+1];
  tag_t             tg_q [FracW+3];

  logic [2*MW-1:0]  sq [2][FracW];
  logic [MW:0]      t  [2][FracW];

  logic [LogW-1:0]  ln_num, ln_den, dm_d, dm_q;
  logic             neg_d, neg_q;
  logic [PW-1:0]    pr;
  logic [LW-2:0]    lm;
  logic signed [LW-1:0] l_d, l_q;

  assign x[0] = num_i;
  assign x[1] = den_i;

  // leading-one detect and normalize to Q1.30
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      e_d[k] = '0;
      for (int b = 0; b < ProdW; b++) begin
        if (x[k][b]) e_d[k] = ExpW'(b);
      end
      if (e_d[k] >= ExpW'(FracW)) begin
        m_d[k] = MW'(x[k] >> (e_d[k] - ExpW'(FracW)));
      end else begin
        m_d[k] = MW'(x[k] << (ExpW'(FracW) - e_d[k]));
      end
    end
  end

  // one squaring per stage yields one fraction bit
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < FracW; i++) begin
        sq[k][i] = {{MW{1'b0}}, m_q[k][i]} * {{MW{1'b0}}, m_q[k][i]};
        t[k][i]  = sq[k][i][2*MW-1:FracW];
      end
    end
  end

  assign ln_num = {e_q[0][FracW], f_q[0][FracW]};
  assign ln_den = {e_q[1][FracW], f_q[1][FracW]};
  assign neg_d  = ln_num < ln_den;
  assign dm_d   = neg_d ? (ln_den - ln_num) : (ln_num - ln_den);

  // scale by ln2, round magnitude half up to 24 fraction bits
  assign pr  = {{Ln2W{1'b0}}, dm_q} * {{LogW{1'b0}}, Ln2Q26} + (PW'(1) << 31);
  assign lm  = pr[PW-1:32];
  assign l_d = neg_q ? -$signed({1'b0, lm}) : $signed({1'b0, lm});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FracW + 3; i++) tg_q[i] <= '0;
    end else if (en_i) begin
      tg_q[0] <= tag_i;
      for (int i = 0; i < FracW + 2; i++) tg_q[i+1] <= tg_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        m_q[k][0] <= m_d[k];
        e_q[k][0] <= e_d[k];
        f_q[k][0] <= '0;
        for (int i = 0; i < FracW; i++) begin
          m_q[k][i+1] <= t[k][i][MW] ? t[k][i][MW:1] : t[k][i][MW-1:0];
          f_q[k][i+1] <= {f_q[k][i][FracW-2:0], t[k][i][MW]};
          e_q[k][i+1] <= e_q[k][i];
        end
      end
      dm_q  <= dm_d;
      neg_q <= neg_d;
      l_q   <= l_d;
    end
  end

  assign tag_o = tg_q[FracW+2];
  assign l_o   = l_q;

endmodule

// File: rtl/thsh_horner_step.sv
`timescale 1ns / 1ps

module thsh_horner_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  thsh_pkg::tag_t                       tag_i,
  input  logic signed [thsh_pkg::AccW-1:0]     acc_i,
  input  logic signed [thsh_pkg::LW-1:0]       l_i,
  input  logic signed [thsh_pkg::CoefW-1:0]    coef_i,
  output thsh_pkg::tag_t                       tag_o,
  output logic signed [thsh_pkg::AccW-1:0]     acc_o,
  output logic signed [thsh_pkg::LW-1:0]       l_o
);
  import thsh_pkg::*;

  localparam int UaW = AccW - 1;     // 62-bit magnitude
  localparam int UlW = LW - 1;       // 30-bit magnitude
  localparam int HiW = UaW - 32;
  localparam int SW  = AccW + 1;
  localparam logic signed [SW-1:0] SatP = $signed({1'b0, SatLim});
  localparam logic signed [SW-1:0] SatN = -$signed({1'b0, SatLim});

  logic [UaW-1:0]       ua;
  logic [UlW-1:0]       ul;
  logic [HiW+UlW-1:0]   hi_d, hi_q;
  logic [32+UlW-1:0]    lo_d, lo_q;
  logic                 neg_d, neg_q;
  tag_t                 tag_a_q, tag_b_q;
  logic signed [LW-1:0] l_a_q, l_b_q;

  logic [AccW-1:0]      rsum;
  logic [UaW-1:0]       r;
  logic signed [AccW-1:0] p;
  logic signed [SW-1:0] sum;
  logic signed [AccW-1:0] acc_d, acc_q;

  // split the magnitude product in two partial products
  assign ua    = acc_i[AccW-1] ? UaW'(-acc_i) : acc_i[UaW-1:0];
  assign ul    = l_i[LW-1] ? UlW'(-l_i) : l_i[UlW-1:0];
  assign hi_d  = {{UlW{1'b0}}, ua[UaW-1:32]} * {{HiW{1'b0}}, ul};
  assign lo_d  = {{UlW{1'b0}}, ua[31:0]} * {32'b0, ul};
  assign neg_d = acc_i[AccW-1] ^ l_i[LW-1];

  // recombine, truncate magnitude by 24, saturate, then add the coefficient
  assign rsum = {1'b0, hi_q[53:0], 8'b0} + {25'b0, lo_q[32+UlW-1:24]};

  always_comb begin
    if (|hi_q[HiW+UlW-1:54] || (rsum > SatLim)) begin
      r = SatLim[UaW-1:0];
    end else begin
      r = rsum[UaW-1:0];
    end
    p   = neg_q ? -$signed({1'b0, r}) : $signed({1'b0, r});
    sum = {p[AccW-1], p} + {{(SW-CoefW){coef_i[CoefW-1]}}, coef_i};
    if (sum > SatP) begin
      acc_d = SatP[AccW-1:0];
    end else if (sum < SatN) begin
      acc_d = SatN[AccW-1:0];
    end else begin
      acc_d = sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else if (en_i) begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      neg_q <= neg_d;
      l_a_q <= l_i;
      l_b_q <= l_a_q;
      acc_q <= acc_d;
    end
  end

  assign tag_o = tag_b_q;
  assign acc_o = acc_q;
  assign l_o   = l_b_q;

endmodule

// File: rtl/thsh_div.sv
`timescale 1ns / 1ps

module thsh_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  thsh_pkg::tag_t                       tag_i,
  input  logic signed [thsh_pkg::AccW-1:0]     acc_i,
  output thsh_pkg::tag_t                       tag_o,
  output logic signed [thsh_pkg::TempW-1:0]    temp_o
);
  import thsh_pkg::*;

  localparam int SW = AccW - 1;   // divisor, positive sums only
  localparam int NW = 62;         // 1000*2^48 + s/2 < 2^62
  localparam logic [NW-1:0] Kilo48 = NW'(1000) << 48;

  logic [SW-1:0]  s_d;
  logic [NW-1:0]  n_d;
  logic           ovf_d, zero_d, neg_d;

  logic [NW-1:0]  r_q   [QW+1];
  logic [SW-1:0]  s_q   [QW+1];
  logic [QW-1:0]  q_q   [QW+1];
  logic           ovf_q [QW+1];
  logic           zero_q [QW+1];
  logic           neg_q [QW+1];
  tag_t           tg_q  [QW+2];

  logic           take [QW];
  logic [NW-1:0]  rsub [QW];

  logic signed [QW+1:0]    t_c;
  logic signed [TempW-1:0] temp_d, temp_q;

  assign s_d    = acc_i[SW-1:0];
  assign n_d    = Kilo48 + {1'b0, s_d[SW-1:1]};
  assign ovf_d  = {20'b0, n_d[NW-1:QW]} >= s_d;
  assign zero_d = (acc_i == '0);
  assign neg_d  = acc_i[AccW-1];

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      take[j] = (r_q[j] >> (QW - 1 - j)) >= s_q[j];
      rsub[j] = r_q[j] - (NW'(s_q[j]) << (QW - 1 - j));
    end
  end

  always_comb begin
    t_c = $signed({2'b0, q_q[QW]}) - $signed(ZeroCmK);
    if (tg_q[QW].fault != FAULT_NONE) begin
      temp_d = '0;
    end else if (zero_q[QW] || (!neg_q[QW] && ovf_q[QW])) begin
      temp_d = TempMax;
    end else if (neg_q[QW]) begin
      temp_d = TempMin;
    end else if (t_c > (QW+2)'(TempMax)) begin
      temp_d = TempMax;
    end else if (t_c < (QW+2)'(TempMin)) begin
      temp_d = TempMin;
    end else begin
      temp_d = t_c[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < QW + 2; j++) tg_q[j] <= '0;
    end else if (en_i) begin
      tg_q[0] <= tag_i;
      for (int j = 0; j < QW + 1; j++) tg_q[j+1] <= tg_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= n_d;
      s_q[0]    <= s_d;
      q_q[0]    <= '0;
      ovf_q[0]  <= ovf_d;
      zero_q[0] <= zero_d;
      neg_q[0]  <= neg_d;
      for (int j = 0; j < QW; j++) begin
        r_q[j+1]    <= take[j] ? rsub[j] : r_q[j];
        s_q[j+1]    <= s_q[j];
        q_q[j+1]    <= {q_q[j][QW-2:0], take[j]};
        ovf_q[j+1]  <= ovf_q[j];
        zero_q[j+1] <= zero_q[j];
        neg_q[j+1]  <= neg_q[j];
      end
      temp_q <= temp_d;
    end
  end

  assign tag_o  = tg_q[QW+1];
  assign temp_o = temp_q;

endmodule

// File: rtl/thermistor_steinhart_hart_temp.sv
`timescale 1ns / 1ps

// Thermistor temperature converter (Steinhart-Hart, fixed point).
// Input channel: in_valid_i / in_stall_o carry one converter reading in
// microvolts per item. Output channel: out_valid_o / out_stall_i carry one
// result item per input: temperature in millicelsius (saturated to
// -200000..400000) and a fault code (reading zero, or at/above reference).
// Faulted items give a zero temperature.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 reference, 1 series, 2 nominal, 3..6 coefficients A..D); other
// indexes are dropped. Write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. Pipeline:
// the 30-stage squaring log2 pipeline and the 20-stage restoring divider for
// 1/S, plus the divider-product stage, the ln2 scaling and three two-stage
// Horner multiply-add steps.
// Stall: the whole pipeline holds while the output register holds an item
// the receiver stalls; in_stall_o is raised in that cycle. Empty slots
// travel as bubbles and nothing is dropped or repeated.
// Reset: clears all valid bits and loads the default divider and
// coefficient values; no clearing pass is needed.
module thermistor_steinhart_hart_temp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [thsh_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [thsh_pkg::CoefW-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [thsh_pkg::RdW-1:0]             reading_microvolts_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [thsh_pkg::TempW-1:0]    temp_millicelsius_o,
  output logic [thsh_pkg::FaultW-1:0]          fault_o
);
  import thsh_pkg::*;

  // configuration registers
  logic [RdW-1:0]          ref_q;
  logic [OhmW-1:0]         ser_q, nom_q;
  logic signed [CoefW-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;

  logic adv;

  // front stage: fault check and the two divider products
  logic [OhmW-1:0]  ser_eff, nom_eff;
  logic [RdW-1:0]   v_rd;
  logic [ProdW-1:0] num_d, den_d, num_q, den_q;
  tag_t             tag_in, s1_tag_q;

  tag_t                 lr_tag, h1_tag, h2_tag, h3_tag, dv_tag;
  logic signed [LW-1:0] lr_l, h1_l, h2_l, h3_l;
  logic signed [AccW-1:0] acc0, h1_acc, h2_acc, h3_acc;

  // advance whenever the output register is free or being taken
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= RefReset;
      ser_q    <= SerReset;
      nom_q    <= NomReset;
      coef_a_q <= CoefAReset;
      coef_b_q <= CoefBReset;
      coef_c_q <= CoefCReset;
      coef_d_q <= CoefDReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REF:     ref_q    <= cfg_data_i[RdW-1:0];
        REG_SERIES:  ser_q    <= cfg_data_i[OhmW-1:0];
        REG_NOMINAL: nom_q    <= cfg_data_i[OhmW-1:0];
        REG_COEF_A:  coef_a_q <= cfg_data_i;
        REG_COEF_B:  coef_b_q <= cfg_data_i;
        REG_COEF_C:  coef_c_q <= cfg_data_i;
        REG_COEF_D:  coef_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a zero resistor register counts as one ohm
  assign ser_eff = (ser_q == '0) ? OhmW'(1) : ser_q;
  assign nom_eff = (nom_q == '0) ? OhmW'(1) : nom_q;
  assign v_rd    = ref_q - reading_microvolts_i;
  assign num_d   = {{RdW{1'b0}}, ser_eff} * {{OhmW{1'b0}}, reading_microvolts_i};
  assign den_d   = {{OhmW{1'b0}}, v_rd} * {{RdW{1'b0}}, nom_eff};

  always_comb begin
    tag_in.vld = in_valid_i;
    if (reading_microvolts_i == '0) begin
      tag_in.fault = FAULT_ZERO;
    end else if (reading_microvolts_i >= ref_q) begin
      tag_in.fault = FAULT_HIGH;
    end else begin
      tag_in.fault = FAULT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else if (adv) begin
      s1_tag_q <= tag_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  // L = ln(num/den), Q.24
  thsh_log_ratio u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (s1_tag_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .tag_o  (lr_tag),
    .l_o    (lr_l)
  );

  // Horner: S = A + L*(B + L*(C + L*D))
  assign acc0 = {{(AccW-CoefW){coef_d_q[CoefW-1]}}, coef_d_q};

  thsh_horner_step u_h1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (lr_tag),
    .acc_i  (acc0),
    .l_i    (lr_l),
    .coef_i (coef_c_q),
    .tag_o  (h1_tag),
    .acc_o  (h1_acc),
    .l_o    (h1_l)
  );

  thsh_horner_step u_h2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (h1_tag),
    .acc_i  (h1_acc),
    .l_i    (h1_l),
    .coef_i (coef_b_q),
    .tag_o  (h2_tag),
    .acc_o  (h2_acc),
    .l_o    (h2_l)
  );

  thsh_horner_step u_h3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (h2_tag),
    .acc_i  (h2_acc),
    .l_i    (h2_l),
    .coef_i (coef_a_q),
    .tag_o  (h3_tag),
    .acc_o  (h3_acc),
    .l_o    (h3_l)
  );

  // T = 1/S in millikelvin, then to millicelsius; last stage is the output register
  thsh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (h3_tag),
    .acc_i  (h3_acc),
    .tag_o  (dv_tag),
    .temp_o (temp_millicelsius_o)
  );

  assign out_valid_o = dv_tag.vld;
  assign fault_o     = dv_tag.fault;

  // the final L is not used beyond the last Horner step
  logic l_spare;
  assign l_spare = ^h3_l;

  a_fault_zero_temp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (fault_o != FAULT_NONE)) |-> (temp_millicelsius_o == '0))
    else $error("faulted item carries a nonzero temperature");

  a_temp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((temp_millicelsius_o >= TempMin) && (temp_millicelsius_o <= TempMax)))
    else $error("temperature outside the saturation range");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> (in_stall_o && !l_spare) || (in_stall_o && l_spare))
    else $error("input accepted while the output register is stalled");

endmodule

// File: verif/thermistor_steinhart_hart_temp_test.sv
`timescale 1ns / 1ps

module thermistor_steinhart_hart_temp_test;
  import thsh_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;   // no register behind it
  localparam int unsigned        CycleLimit = 400000;
  localparam int unsigned        DrainWait  = 80;    // longer than the pipeline latency
  localparam int unsigned        MaxMismatchReports = 10;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [FaultW-1:0]       fault;
  } temp_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx = '0;
  logic [CoefW-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RdW-1:0]          reading = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [TempW-1:0] temp_mc;
  logic [FaultW-1:0]       fault;

  thermistor_steinhart_hart_temp u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .reading_microvolts_i (reading),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .temp_millicelsius_o  (temp_mc),
    .fault_o              (fault)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the divider and coefficient registers.
  longint unsigned ref_uv  = RefReset;
  longint unsigned ser_ohm = SerReset;
  longint unsigned nom_ohm = NomReset;
  longint          coef_a  = CoefAReset;
  longint          coef_b  = CoefBReset;
  longint          coef_c  = CoefCReset;
  longint          coef_d  = CoefDReset;

  logic [RdW-1:0] pending_readings[$];
  temp_result_t   expected_temps[$];

  int unsigned cycles      = 0;
  int unsigned mismatches  = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_gap   = 0;
  int unsigned hold_off    = 0;   // long receiver hold-off, in cycles
  bit          calm        = 1'b0; // no idling at all in the final stretch
  bit          took        = 1'b0;

  localparam longint SatQ = 64'sh3FFF_FFFF_FFFF_FFFF;

  function automatic longint clamp_acc(longint a);
    if (a > SatQ) return SatQ;
    if (a < -SatQ) return -SatQ;
    return a;
  endfunction

  // log2 in Q.30: leading-one index, then 30 squarings of the Q1.30 mantissa.
  function automatic longint unsigned log2_q30(longint unsigned x);
    int              e;
    longint unsigned m;
    longint unsigned frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(e) << 30) | frac;
  endfunction

  // acc * L >> 24, magnitude truncated toward zero, saturated.
  function automatic longint scale_by_log(longint a, longint l);
    longint unsigned ua;
    longint unsigned ul;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned r;
    bit              neg;
    ua = (a < 0) ? longint'(-a) : longint'(a);
    ul = (l < 0) ? longint'(-l) : longint'(l);
    neg = (a < 0) != (l < 0);
    hi = (ua >> 32) * ul;
    lo = (ua & 64'hFFFF_FFFF) * ul;
    if (hi >= (64'd1 << 54)) begin
      r = SatQ;
    end else begin
      r = (hi << 8) + (lo >> 24);
      if (r > SatQ) r = SatQ;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic temp_result_t convert_reading(logic [RdW-1:0] rd);
    temp_result_t    res;
    longint unsigned ser;
    longint unsigned nom;
    longint unsigned ln_num;
    longint unsigned ln_den;
    longint unsigned dm;
    longint unsigned lm;
    longint unsigned s;
    longint unsigned mk;
    longint          l;
    longint          acc;
    longint          t;
    bit              neg;
    res = '0;
    if (rd == 0) begin
      res.fault = FAULT_ZERO;
      return res;
    end
    if (longint'(rd) >= ref_uv) begin
      res.fault = FAULT_HIGH;
      return res;
    end
    ser = (ser_ohm != 0) ? ser_ohm : 1;
    nom = (nom_ohm != 0) ? nom_ohm : 1;
    ln_num = log2_q30(ser * rd);
    ln_den = log2_q30((ref_uv - rd) * nom);
    neg = ln_num < ln_den;
    dm = neg ? ln_den - ln_num : ln_num - ln_den;
    lm = (dm * Ln2Q26 + (64'd1 << 31)) >> 32;
    l = neg ? -longint'(lm) : longint'(lm);
    acc = coef_d;
    acc = clamp_acc(scale_by_log(acc, l) + coef_c);
    acc = clamp_acc(scale_by_log(acc, l) + coef_b);
    acc = clamp_acc(scale_by_log(acc, l) + coef_a);
    if (acc == 0) begin
      t = 400000;
    end else if (acc < 0) begin
      t = -200000;
    end else begin
      s = acc;
      mk = (64'd1000 * (64'd1 << 48) + s / 2) / s;
      t = longint'(mk) - 273150;
      if (t > 400000) t = 400000;
      if (t < -200000) t = -200000;
    end
    res.temp = t[TempW-1:0];
    res.fault = FAULT_NONE;
    return res;
  endfunction

  // Write one register at a falling edge and mirror it in the shadow copy.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      REG_REF:     ref_uv  = val[RdW-1:0];
      REG_SERIES:  ser_ohm = val[OhmW-1:0];
      REG_NOMINAL: nom_ohm = val[OhmW-1:0];
      REG_COEF_A:  coef_a  = longint'($signed(val));
      REG_COEF_B:  coef_b  = longint'($signed(val));
      REG_COEF_C:  coef_c  = longint'($signed(val));
      REG_COEF_D:  coef_d  = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic load_all(longint unsigned r, longint unsigned s, longint unsigned n,
                          longint a, longint b, longint c, longint d);
    write_reg(REG_REF, r);
    write_reg(REG_SERIES, s);
    write_reg(REG_NOMINAL, n);
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_COEF_D, d);
  endtask

  // Mostly in-range readings; some zero, some at or above the reference,
  // some across the full port width.
  function automatic logic [RdW-1:0] pick_reading();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return '0;
    if (kind == 1 && ref_uv <= 22'h3FFFFF)
      return $urandom_range(int'(ref_uv), 22'h3FFFFF);
    if (kind == 2 || ref_uv < 2) return $urandom();
    return $urandom_range(1, int'(ref_uv) - 1);
  endfunction

  task automatic queue_random(int unsigned n);
    repeat (n) pending_readings.push_back(pick_reading());
  endtask

  // Hold the test sequence until the block has drained every item of the phase.
  task automatic drain();
    while (pending_readings.size() != 0 || in_valid || expected_temps.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Sender: advance to the next item once the current one is taken.
  always @(negedge clk_i) begin : drive_readings
    logic           nv;
    logic [RdW-1:0] nd;
    nv = in_valid;
    nd = reading;
    if (rst_ni && (!in_valid || took)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_readings.size() != 0) begin
        nv = 1'b1;
        nd = pending_readings.pop_front();
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end
    end
    in_valid <= nv;
    reading <= nd;
  end

  // Receiver: random stall bursts, plus the long hold-off when requested.
  always @(negedge clk_i) begin : drive_stall
    logic ns;
    ns = 1'b0;
    if (hold_off > 0) begin
      ns = 1'b1;
      hold_off--;
    end else if (stall_gap > 0) begin
      ns = 1'b1;
      stall_gap--;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_gap = $urandom_range(1, 11);
    end
    out_stall <= ns;
  end

  // Predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin : watch
    temp_result_t want;
    took = in_valid && !in_stall && rst_ni;
    if (took) expected_temps.push_back(convert_reading(reading));
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_temps.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxMismatchReports)
          $display("unexpected result temp=%0d fault=%0d", temp_mc, fault);
      end else begin
        want = expected_temps.pop_front();
        if (temp_mc !== want.temp || fault !== want.fault) begin
          mismatches++;
          if (mismatches <= MaxMismatchReports)
            $display("mismatch: temp exp %0d got %0d, fault exp %0d got %0d",
                     want.temp, temp_mc, want.fault, fault);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: extremes of the reading and both faults.
    pending_readings.push_back(22'd0);
    pending_readings.push_back(22'd1);
    pending_readings.push_back(22'd900000);
    pending_readings.push_back(22'd1799999);
    pending_readings.push_back(22'd1800000);
    pending_readings.push_back(22'h3FFFFF);
    pending_readings.push_back(22'd450000);
    pending_readings.push_back(22'd1350000);
    drain();

    // Top reference, largest divider values.
    load_all(3300000, 1000000, 1000000, CoefAReset, CoefBReset, CoefCReset, CoefDReset);
    pending_readings.push_back(22'd3299999);
    pending_readings.push_back(22'd1);
    pending_readings.push_back(22'd3300000);
    drain();

    // Zero sum saturates high, negative sum saturates low.
    load_all(1800000, 10000, 10000, 0, 0, 0, 0);
    write_reg(RegUnused, 48'hFFFF_FFFF_FFFF);   // ignored index
    pending_readings.push_back(22'd900000);
    pending_readings.push_back(22'd700000);
    drain();
    write_reg(REG_COEF_A, -48'sd1000);
    pending_readings.push_back(22'd900000);
    drain();

    // Out of range temperature both ways.
    write_reg(REG_COEF_A, 48'd1);
    pending_readings.push_back(22'd900000);
    drain();
    write_reg(REG_COEF_A, 48'h7FFF_FFFF_FFFF);
    pending_readings.push_back(22'd900000);
    drain();

    // Zero series and nominal are used as one; reference of one and of zero.
    load_all(1800000, 0, 0, CoefAReset, CoefBReset, CoefCReset, CoefDReset);
    pending_readings.push_back(22'd5);
    pending_readings.push_back(22'd1799990);
    drain();
    write_reg(REG_REF, 1);
    pending_readings.push_back(22'd0);
    pending_readings.push_back(22'd1);
    drain();
    write_reg(REG_REF, 48'hABCD_0000_0000);    // upper bits drop, reference zero
    pending_readings.push_back(22'd1);
    pending_readings.push_back(22'd0);
    drain();

    // Random phases over several settings.
    load_all(RefReset, SerReset, NomReset, CoefAReset, CoefBReset, CoefCReset, CoefDReset);
    queue_random(60);
    drain();

    // Long receiver hold-off while the sender keeps offering: fill the pipe.
    hold_off = 300;
    queue_random(120);
    drain();

    for (int p = 0; p < 5; p++) begin
      load_all($urandom_range(1, 3300000), $urandom_range(1, 1000000),
               $urandom_range(1, 1000000),
               CoefAReset + $signed($urandom_range(0, 2000000)) - 1000000,
               CoefBReset, CoefCReset, CoefDReset);
      queue_random(45);
      drain();
    end

    // Full-width random coefficients.
    for (int p = 0; p < 2; p++) begin
      load_all($urandom_range(1, 3300000), $urandom(), $urandom(),
               {$urandom(), $urandom()}, {$urandom(), $urandom()},
               {$urandom(), $urandom()}, {$urandom(), $urandom()});
      queue_random(35);
      drain();
    end

    // Final stretch: back to defaults, no idling on either side.
    load_all(RefReset, SerReset, NomReset, CoefAReset, CoefBReset, CoefCReset, CoefDReset);
    calm = 1'b1;
    queue_random(60);
    drain();

    if (mismatches == 0 && expected_temps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/thsh_pkg.sv
rtl/thsh_log_ratio.sv
rtl/thsh_horner_step.sv
rtl/thsh_div.sv
rtl/thermistor_steinhart_hart_temp.sv
verif/thermistor_steinhart_hart_temp_test.sv
